### hw/rtl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// Sparse set slot allocator package
// Sizes, operation codes and status codes shared by the allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

    localparam int SLOTS         = 256;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int ID_W          = $clog2(SLOTS);
    localparam int CNT_W         = ID_W + 1;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;
    localparam logic [1:0] OP_WRITE   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef logic [ID_W-1:0]          id_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [PAYLOAD_WIDTH-1:0] payload_t;

endpackage

`default_nettype wire

### hw/rtl/ssa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sparse_set_slot_allocator.sv
// ----------------------------------------------------------------------------
// Sparse set slot allocator
// Hands out slot ids and keeps the payloads of live ids packed in memory.
//
// An operation enters on the input channel (in_valid, in_stall) as opcode,
// slot_id and write_data, and its status leaves on the output channel
// (out_valid, out_stall). Every transfer in gives exactly one transfer out.
// The block works on one operation at a time: in_stall stays high from the
// transfer in until the status has been taken. A small sequencer drives the
// map, payload and free stack RAMs and one shared add/subtract unit for the
// counters. Lookup and any refused operation go from decode to the status;
// allocate passes through a commit state, write through its own commit
// state, and release through a move and a push state, as the registered RAM
// reads and the counter updates that share the one adder require. The next
// operation can be taken in the cycle after the status transfer. The status is
// held while out_stall is high, and the next operation is taken only once it
// has left. Reset clears all counters and marks every id and payload
// position empty at once, so the block is ready in the first cycle after it.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_set_slot_allocator (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           opcode,
    input  wire logic [7:0]                           slot_id,
    input  wire logic [63:0]                          write_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [1:0]                                status
);

    import ssa_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_A_COMMIT = 3'd2;
    localparam logic [2:0] S_R_MOVE   = 3'd3;
    localparam logic [2:0] S_R_PUSH   = 3'd4;
    localparam logic [2:0] S_W_COMMIT = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0]   state_reg,  state_next;
    logic [1:0]   op_reg;
    logic [7:0]   id_reg;
    payload_t     data_reg;
    logic [1:0]   status_reg, status_next;
    cnt_t         live_reg,   live_next;
    cnt_t         free_reg,   free_next;
    cnt_t         fresh_reg,  fresh_next;
    id_t          new_id_reg, new_id_next;
    logic         stack_reg,  stack_next;
    id_t          last_reg,   last_next;
    logic [SLOTS-1:0] id_valid_reg, id_valid_next;
    logic [SLOTS-1:0] pl_valid_reg, pl_valid_next;

    cnt_t au_a;
    logic au_dec;
    cnt_t au_sum;

    id_t  id_idx;
    logic id_live;
    id_t  alloc_id;

    logic     i2p_we,  i2p_re;
    id_t      i2p_waddr, i2p_wdata, i2p_rdata;
    logic     p2i_we,  p2i_re;
    id_t      p2i_waddr, p2i_wdata, p2i_rdata;
    logic     pay_we,  pay_re;
    id_t      pay_waddr;
    payload_t pay_wdata, pay_rdata, pay_last;
    logic     stk_we,  stk_re;
    id_t      stk_waddr, stk_wdata, stk_raddr, stk_rdata;

    assign au_sum = au_dec ? au_a - 1'b1 : au_a + 1'b1;

    assign id_idx   = ID_W'(id_reg);
    assign id_live  = (32'(id_reg) < SLOTS) && id_valid_reg[id_idx];
    assign alloc_id = stack_reg ? stk_rdata : new_id_reg;
    assign pay_last = pl_valid_reg[last_reg] ? pay_rdata : '0;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign status    = status_reg;

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        live_next     = live_reg;
        free_next     = free_reg;
        fresh_next    = fresh_reg;
        new_id_next   = new_id_reg;
        stack_next    = stack_reg;
        last_next     = last_reg;
        id_valid_next = id_valid_reg;
        pl_valid_next = pl_valid_reg;
        au_a          = live_reg;
        au_dec        = 1'b0;
        i2p_we = 1'b0; i2p_re = 1'b0; i2p_waddr = '0; i2p_wdata = '0;
        p2i_we = 1'b0; p2i_re = 1'b0; p2i_waddr = '0; p2i_wdata = '0;
        pay_we = 1'b0; pay_re = 1'b0; pay_waddr = '0; pay_wdata = '0;
        stk_we = 1'b0; stk_re = 1'b0; stk_waddr = '0; stk_wdata = '0;
        stk_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (live_reg == cnt_t'(SLOTS))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else if (free_reg != '0)
                        begin
                            au_a       = free_reg;
                            au_dec     = 1'b1;
                            free_next  = au_sum;
                            stk_re     = 1'b1;
                            stk_raddr  = au_sum[ID_W-1:0];
                            stack_next = 1'b1;
                            state_next = S_A_COMMIT;
                        end
                        else
                        begin
                            au_a        = fresh_reg;
                            fresh_next  = au_sum;
                            new_id_next = fresh_reg[ID_W-1:0];
                            stack_next  = 1'b0;
                            state_next  = S_A_COMMIT;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (!id_live)
                        begin
                            status_next = ST_ABSENT;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            au_a       = live_reg;
                            au_dec     = 1'b1;
                            last_next  = au_sum[ID_W-1:0];
                            i2p_re     = 1'b1;
                            p2i_re     = 1'b1;
                            pay_re     = 1'b1;
                            state_next = S_R_MOVE;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        status_next = id_live ? ST_OK : ST_ABSENT;
                        state_next  = S_RESP;
                    end
                    default:
                    begin
                        if (!id_live)
                        begin
                            status_next = ST_ABSENT;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            i2p_re     = 1'b1;
                            state_next = S_W_COMMIT;
                        end
                    end
                endcase
            end
            S_A_COMMIT:
            begin
                i2p_we    = 1'b1;
                i2p_waddr = alloc_id;
                i2p_wdata = live_reg[ID_W-1:0];
                p2i_we    = 1'b1;
                p2i_waddr = live_reg[ID_W-1:0];
                p2i_wdata = alloc_id;
                id_valid_next[alloc_id] = 1'b1;
                au_a        = live_reg;
                live_next   = au_sum;
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_R_MOVE:
            begin
                if (i2p_rdata != last_reg)
                begin
                    pay_we    = 1'b1;
                    pay_waddr = i2p_rdata;
                    pay_wdata = pay_last;
                    p2i_we    = 1'b1;
                    p2i_waddr = i2p_rdata;
                    p2i_wdata = p2i_rdata;
                    i2p_we    = 1'b1;
                    i2p_waddr = p2i_rdata;
                    i2p_wdata = i2p_rdata;
                    pl_valid_next[i2p_rdata] = 1'b1;
                end
                pl_valid_next[last_reg] = 1'b0;
                id_valid_next[id_idx]   = 1'b0;
                au_a       = live_reg;
                au_dec     = 1'b1;
                live_next  = au_sum;
                state_next = S_R_PUSH;
            end
            S_R_PUSH:
            begin
                stk_we      = 1'b1;
                stk_waddr   = free_reg[ID_W-1:0];
                stk_wdata   = id_idx;
                au_a        = free_reg;
                free_next   = au_sum;
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_W_COMMIT:
            begin
                pay_we    = 1'b1;
                pay_waddr = i2p_rdata;
                pay_wdata = data_reg;
                pl_valid_next[i2p_rdata] = 1'b1;
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            status_reg   <= ST_OK;
            live_reg     <= '0;
            free_reg     <= '0;
            fresh_reg    <= '0;
            stack_reg    <= 1'b0;
            id_valid_reg <= '0;
            pl_valid_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            live_reg     <= live_next;
            free_reg     <= free_next;
            fresh_reg    <= fresh_next;
            stack_reg    <= stack_next;
            id_valid_reg <= id_valid_next;
            pl_valid_reg <= pl_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= opcode;
            id_reg   <= slot_id;
            data_reg <= PAYLOAD_WIDTH'(write_data);
        end
        new_id_reg <= new_id_next;
        last_reg   <= last_next;
    end

    ssa_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_id_to_pos (
        .clk   (clk),
        .we    (i2p_we),
        .waddr (i2p_waddr),
        .wdata (i2p_wdata),
        .re    (i2p_re),
        .raddr (id_idx),
        .rdata (i2p_rdata)
    );

    ssa_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_pos_to_id (
        .clk   (clk),
        .we    (p2i_we),
        .waddr (p2i_waddr),
        .wdata (p2i_wdata),
        .re    (p2i_re),
        .raddr (last_next),
        .rdata (p2i_rdata)
    );

    ssa_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(SLOTS)) u_payload (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .re    (pay_re),
        .raddr (last_next),
        .rdata (pay_rdata)
    );

    ssa_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_free_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

`ifndef NO_ASSERTIONS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= cnt_t'(SLOTS))
        else $error("Live count exceeds the number of slots.");

    a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
        ({1'b0, live_reg} + {1'b0, free_reg} == {1'b0, fresh_reg}))
        else $error("Live and free counts do not add up to the issued ids.");

    a_release_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R_MOVE) |-> id_valid_reg[id_idx])
        else $error("Release moves entries for an id that is not live.");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid ##1 1'b1)
        else $error("A status appeared in the cycle after a transfer in.");

    a_resp_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !in_stall && !out_valid)
        else $error("Block did not return to idle after the status transfer.");
`endif

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse set slot allocator testbench
// Sends allocate, release, lookup and write operations through the input
// channel and checks every status on the output channel against a
// behavioural copy of the slot maps, the free id stack and the counters,
// updated as each operation is accepted. A directed opening covers the empty,
// absent id, reuse and move on release cases. Random phases then fill the
// allocator to capacity, drain it and mix the operations. Both channels idle
// at random, and there is one long receiver hold-off and one full drain by
// the sender.
// ----------------------------------------------------------------------------

module testbench;

    import ssa_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        logic [1:0] op;
        id_t        id;
        payload_t   data;
        bit         hold;
    } slot_req_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [1:0] opcode     = OP_LOOKUP;
    id_t        slot_id    = '0;
    payload_t   write_data = '0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [1:0] status;

    slot_req_t  req_q[$];
    logic [1:0] status_due[$];
    slot_req_t  cur_req;
    logic [1:0] want_status;

    bit         id_live    [SLOTS];
    cnt_t       id_slot_pos[SLOTS];
    id_t        slot_owner [SLOTS];
    payload_t   slot_data  [SLOTS];
    id_t        free_ids   [SLOTS];
    cnt_t       free_cnt   = '0;
    cnt_t       next_fresh = '0;
    cnt_t       live_cnt   = '0;

    int         errors       = 0;
    int         results_seen = 0;
    int         send_gap     = 0;
    int         stall_left   = 0;
    int         quiet        = 0;
    int         allocs_sent  = 0;
    bit         send_calm    = 1'b0;
    bit         recv_calm    = 1'b0;
    bit         hold_next    = 1'b0;

    sparse_set_slot_allocator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .slot_id    (slot_id),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [1:0] apply_slot_op(logic [1:0] op, id_t id, payload_t data);
        id_t  new_id;
        cnt_t pos;
        cnt_t last;
        id_t  last_owner;
        begin
            case (op)
                OP_ALLOC:
                begin
                    if (live_cnt >= SLOTS)
                        return ST_FULL;
                    if (free_cnt > 0)
                    begin
                        free_cnt = free_cnt - 1'b1;
                        new_id   = free_ids[free_cnt];
                    end
                    else if (next_fresh < SLOTS)
                    begin
                        new_id     = next_fresh[ID_W-1:0];
                        next_fresh = next_fresh + 1'b1;
                    end
                    else
                        return ST_FULL;
                    id_slot_pos[new_id] = live_cnt;
                    id_live[new_id]     = 1'b1;
                    slot_owner[live_cnt[ID_W-1:0]] = new_id;
                    live_cnt = live_cnt + 1'b1;
                    return ST_OK;
                end
                OP_RELEASE:
                begin
                    if (!id_live[id] || live_cnt == 0)
                        return ST_ABSENT;
                    pos        = id_slot_pos[id];
                    last       = live_cnt - 1'b1;
                    last_owner = slot_owner[last[ID_W-1:0]];
                    if (pos != last)
                    begin
                        slot_data[pos[ID_W-1:0]]  = slot_data[last[ID_W-1:0]];
                        slot_owner[pos[ID_W-1:0]] = last_owner;
                        id_slot_pos[last_owner]   = pos;
                    end
                    slot_data[last[ID_W-1:0]] = '0;
                    id_live[id]     = 1'b0;
                    id_slot_pos[id] = '0;
                    if (free_cnt < SLOTS)
                    begin
                        free_ids[free_cnt[ID_W-1:0]] = id;
                        free_cnt = free_cnt + 1'b1;
                    end
                    live_cnt = live_cnt - 1'b1;
                    return ST_OK;
                end
                OP_LOOKUP:
                    return id_live[id] ? ST_OK : ST_ABSENT;
                default:
                begin
                    if (!id_live[id])
                        return ST_ABSENT;
                    slot_data[id_slot_pos[id][ID_W-1:0]] = data;
                    return ST_OK;
                end
            endcase
        end
    endfunction

    function automatic int idle_gap(bit calm);
        int r;
        begin
            r = $urandom_range(0, 99);
            if (calm || r < 60)
                return 0;
            else if (r < 92)
                return $urandom_range(1, 3);
            else
                return $urandom_range(4, 30);
        end
    endfunction

    function automatic id_t pick_id();
        int span;
        begin
            span = (allocs_sent < SLOTS) ? allocs_sent : SLOTS;
            if (span > 0 && $urandom_range(0, 99) < 85)
                return id_t'($urandom_range(0, span - 1));
            return id_t'($urandom_range(0, SLOTS - 1));
        end
    endfunction

    function automatic payload_t pick_data();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                return '0;
            else if (r == 1)
                return '1;
            return {$urandom, $urandom};
        end
    endfunction

    task automatic queue_op(logic [1:0] op, id_t id, payload_t data);
        slot_req_t req;
        begin
            req.op    = op;
            req.id    = id;
            req.data  = data;
            req.hold  = hold_next;
            hold_next = 1'b0;
            if (op == OP_ALLOC)
                allocs_sent++;
            req_q.insert(req_q.size(), req);
        end
    endtask

    task automatic plan_phase(int count, int alloc_pct, int release_pct);
        int r;
        begin
            for (int i = 0; i < count; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < alloc_pct)
                    queue_op(OP_ALLOC, id_t'($urandom_range(0, SLOTS - 1)), pick_data());
                else if (r < alloc_pct + release_pct)
                    queue_op(OP_RELEASE, pick_id(), pick_data());
                else if (r[0])
                    queue_op(OP_LOOKUP, pick_id(), pick_data());
                else
                    queue_op(OP_WRITE, pick_id(), pick_data());
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                status_due.insert(status_due.size(),
                                  apply_slot_op(opcode, slot_id, write_data));
                send_gap = idle_gap(send_calm);
                if ($urandom_range(0, 99) == 0)
                    send_calm = !send_calm;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() > 0 && !(req_q[0].hold && status_due.size() > 0))
                begin
                    cur_req    = req_q.pop_front();
                    in_valid   <= 1'b1;
                    opcode     <= cur_req.op;
                    slot_id    <= cur_req.id;
                    write_data <= cur_req.data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status transfer with no operation outstanding: actual %0d", status);
                    errors++;
                end
                else
                begin
                    want_status = status_due.pop_front();
                    if (status !== want_status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", want_status, status);
                        errors++;
                    end
                end
                results_seen++;
                if (results_seen == 700)
                    stall_left = 400;
                if ($urandom_range(0, 99) == 0)
                    recv_calm = !recv_calm;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = idle_gap(recv_calm);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        // Directed opening: empty allocator, absent ids, first allocations, moves on release and id reuse.
        queue_op(OP_LOOKUP,  8'd0,   '0);
        queue_op(OP_RELEASE, 8'd0,   '0);
        queue_op(OP_WRITE,   8'd255, '1);
        queue_op(OP_ALLOC,   8'd255, '1);
        queue_op(OP_ALLOC,   8'd0,   '0);
        queue_op(OP_ALLOC,   8'd170, 64'h5555_5555_5555_5555);
        queue_op(OP_WRITE,   8'd0,   '1);
        queue_op(OP_WRITE,   8'd2,   '0);
        queue_op(OP_WRITE,   8'd1,   64'hA5A5_A5A5_A5A5_A5A5);
        queue_op(OP_LOOKUP,  8'd1,   '0);
        queue_op(OP_RELEASE, 8'd0,   '0);
        queue_op(OP_LOOKUP,  8'd0,   '0);
        queue_op(OP_LOOKUP,  8'd2,   '0);
        queue_op(OP_RELEASE, 8'd0,   '0);
        queue_op(OP_RELEASE, 8'd2,   '0);
        queue_op(OP_ALLOC,   8'd0,   '0);
        queue_op(OP_ALLOC,   8'd0,   '0);
        queue_op(OP_ALLOC,   8'd0,   '0);
        queue_op(OP_RELEASE, 8'd255, '0);
        queue_op(OP_WRITE,   8'd3,   64'h8000_0000_0000_0001);
        queue_op(OP_LOOKUP,  8'd255, '0);
        queue_op(OP_RELEASE, 8'd3,   '0);
        queue_op(OP_RELEASE, 8'd1,   '0);

        plan_phase(350, 85, 5);
        plan_phase(300, 10, 70);
        hold_next = 1'b1;
        plan_phase(300, 35, 35);
        plan_phase(400, 85, 5);
        plan_phase(400, 10, 70);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (req_q.size() == 0 && !in_valid && status_due.size() == 0);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_ram.sv
hw/rtl/sparse_set_slot_allocator.sv
dv/testbench.sv
